// ===== rtl/core/kme_pkg.sv =====
// Shared types, constants and helper functions of the key and mouse event encoder.
package kme_pkg;

  localparam int COORD_W     = 12;
  localparam int SIZE_W      = 13;
  localparam int RAW_W       = 16;
  localparam int BTN_W       = 8;
  localparam int SYM_W       = 29;
  localparam int WORD_W      = 27;
  localparam int DATA_W      = 24;
  localparam int CODE_W      = 9;
  localparam int CMD_W       = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 56;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd480;

  localparam logic [SYM_W-1:0] SYM_Q        = 29'h0071;
  localparam logic [SYM_W-1:0] SYM_CTRL_L   = 29'hffe3;
  localparam logic [SYM_W-1:0] SYM_CTRL_R   = 29'hffe4;
  localparam logic [SYM_W-1:0] SYM_BACKSP   = 29'hff08;
  localparam logic [SYM_W-1:0] SYM_TAB      = 29'hff09;
  localparam logic [SYM_W-1:0] SYM_RETURN   = 29'hff0d;
  localparam logic [SYM_W-1:0] SYM_ESCAPE   = 29'hff1b;
  localparam logic [SYM_W-1:0] SYM_DELETE   = 29'hffff;
  localparam logic [SYM_W-1:0] SYM_LEFT     = 29'hff51;
  localparam logic [SYM_W-1:0] SYM_RIGHT    = 29'hff53;
  localparam logic [SYM_W-1:0] SYM_UP       = 29'hff52;
  localparam logic [SYM_W-1:0] SYM_DOWN     = 29'hff54;
  localparam logic [SYM_W-1:0] SYM_SHIFT_L  = 29'hffe1;
  localparam logic [SYM_W-1:0] SYM_SHIFT_R  = 29'hffe2;
  localparam logic [SYM_W-1:0] SYM_CAPS     = 29'hffe5;
  localparam logic [SYM_W-1:0] PRINT_LO     = 29'h20;
  localparam logic [SYM_W-1:0] PRINT_HI     = 29'h7e;
  localparam logic [SYM_W-1:0] LOWER_LO     = 29'h61;
  localparam logic [SYM_W-1:0] LOWER_HI     = 29'h7a;
  localparam logic [SYM_W-1:0] UPPER_LO     = 29'h41;
  localparam logic [SYM_W-1:0] UPPER_HI     = 29'h5a;
  localparam logic [SYM_W-1:0] CASE_OFFSET  = 29'h20;

  typedef enum logic [CMD_W-1:0] {
    CMD_MOTION    = 3'd0,
    CMD_BTN_DOWN  = 3'd1,
    CMD_BTN_UP    = 3'd2,
    CMD_KEY_DOWN  = 3'd3,
    CMD_KEY_UP    = 3'd4,
    CMD_CLOSE     = 3'd5,
    CMD_BATCH_END = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_MOVE  = 3'd1,
    EV_MDOWN = 3'd2,
    EV_MUP   = 3'd3,
    EV_KDOWN = 3'd4,
    EV_KUP   = 3'd5,
    EV_CHAR  = 3'd6
  } ev_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1
  } reg_idx_t;

  typedef struct packed {
    logic [WORD_W-1:0]  word0;
    logic [WORD_W-1:0]  word1;
    logic               two;
    logic               has_ev;
    logic               quit;
    logic [2:0]         buttons;
    logic [COORD_W-1:0] cur_x;
    logic [COORD_W-1:0] cur_y;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [WORD_W-1:0] make_word(ev_type_t ev, logic [DATA_W-1:0] data);
    return {ev, data};
  endfunction

  function automatic logic [COORD_W-1:0] clamp_coord(logic [RAW_W-1:0] raw,
                                                     logic [SIZE_W-1:0] size);
    logic [COORD_W-1:0] hi;
    if (size == '0) begin
      hi = '0;
    end else if (size[SIZE_W-1]) begin
      hi = '1;
    end else begin
      hi = size[COORD_W-1:0] - COORD_W'(1);
    end
    if (raw[RAW_W-1]) begin
      return '0;
    end else if (raw[RAW_W-2:0] > {{(RAW_W-1-COORD_W){1'b0}}, hi}) begin
      return hi;
    end else begin
      return raw[COORD_W-1:0];
    end
  endfunction

  function automatic logic [CODE_W-1:0] key_code(logic [SYM_W-1:0] sym);
    logic [CODE_W-1:0] code;
    case (sym)
      SYM_BACKSP:  code = 9'h100;
      SYM_TAB:     code = 9'h101;
      SYM_RETURN:  code = 9'h102;
      SYM_ESCAPE:  code = 9'h103;
      SYM_DELETE:  code = 9'h104;
      SYM_LEFT:    code = 9'h105;
      SYM_RIGHT:   code = 9'h106;
      SYM_UP:      code = 9'h107;
      SYM_DOWN:    code = 9'h108;
      SYM_SHIFT_L: code = 9'h110;
      SYM_SHIFT_R: code = 9'h111;
      SYM_CTRL_L:  code = 9'h112;
      SYM_CTRL_R:  code = 9'h113;
      SYM_CAPS:    code = 9'h114;
      default: begin
        if (sym >= PRINT_LO && sym <= PRINT_HI) begin
          code = sym[CODE_W-1:0];
        end else begin
          code = '0;
        end
      end
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/core/key_mouse_event_encoder_top.sv =====
// Top level of the key and mouse event encoder.
// Each accepted input beat yields one result beat, or two for a key press that gives both a
// key-code word and a character word. The front end takes one input beat per cycle while the
// four-entry job queue before the output stage has room. The output stage sends one result
// beat per cycle while out_tready is high, so single-result items go out back to back and a
// two-word key press holds the output for both beats. Configuration writes are always ready.
module key_mouse_event_encoder_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // command
  input  logic [kme_pkg::CMD_W-1:0]       in_tuser,
  // pos_x, pos_y, button_id, sym_plain, sym_shifted, shift_held, lock_held, zero pad
  input  logic [kme_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // has_event
  output logic                            out_tuser,
  // event_word, quit, button_state, cursor_x, cursor_y, zero pad
  output logic [kme_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kme_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kme_pkg::SIZE_W-1:0]      cfg_data
);
  import kme_pkg::*;

  q_stat_t q_stat;
  logic    push, pop;
  job_t    push_job, head_job;

  kme_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_job  (push_job)
  );

  kme_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  kme_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_job   (head_job),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_no_event_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast)
    else $error("Result without an event is not the last beat of its item.");

  a_second_beat_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && out_tlast && out_tuser)
    else $error("Second word of a key press did not follow at once.");

  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> q_stat.full && !q_stat.empty)
    else $error("Input stalled while the job queue has room.");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> !pop)
    else $error("Output stage took a job from an empty queue.");

endmodule

// ===== rtl/core/kme_front.sv =====
// Front end: accepts input beats and configuration writes, tracks pointer, button and modifier state, builds jobs.
module kme_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [kme_pkg::CMD_W-1:0]       in_tuser,
  input  logic [kme_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kme_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kme_pkg::SIZE_W-1:0]      cfg_data,
  input  kme_pkg::q_stat_t                q_stat,
  output logic                            push,
  output kme_pkg::job_t                   push_job
);
  import kme_pkg::*;

  logic [SIZE_W-1:0]  width_r, height_r;
  logic [COORD_W-1:0] rep_x_r, rep_y_r, pend_x_r, pend_y_r;
  logic [COORD_W-1:0] rep_x_nxt, rep_y_nxt, pend_x_nxt, pend_y_nxt;
  logic               motion_r, motion_nxt;
  logic [2:0]         held_r, held_nxt;
  logic               ctrl_r, ctrl_nxt;

  cmd_t               cmd;
  logic [RAW_W-1:0]   pos_x, pos_y;
  logic [BTN_W-1:0]   button_id;
  logic [SYM_W-1:0]   sym_plain, sym_shifted, ch;
  logic               shift_held, lock_held;
  logic [CODE_W-1:0]  code;
  logic [2:0]         bit_sel;
  logic               kw_v, ch_v, quit;
  logic [WORD_W-1:0]  kword, cword, w0, w1;
  logic [1:0]         nw;

  assign cmd         = cmd_t'(in_tuser);
  assign pos_x       = in_tdata[15:0];
  assign pos_y       = in_tdata[31:16];
  assign button_id   = in_tdata[39:32];
  assign sym_plain   = in_tdata[68:40];
  assign sym_shifted = in_tdata[97:69];
  assign shift_held  = in_tdata[98];
  assign lock_held   = in_tdata[99];

  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign code = key_code(sym_plain);

  always_comb begin
    ch = shift_held ? sym_shifted : sym_plain;
    if (lock_held) begin
      if (ch >= LOWER_LO && ch <= LOWER_HI) begin
        ch = ch - CASE_OFFSET;
      end else if (ch >= UPPER_LO && ch <= UPPER_HI) begin
        ch = ch + CASE_OFFSET;
      end
    end
  end

  always_comb begin
    unique case (button_id)
      8'd1:    bit_sel = 3'b100;
      8'd2:    bit_sel = 3'b010;
      8'd3:    bit_sel = 3'b001;
      default: bit_sel = 3'b000;
    endcase
  end

  always_comb begin
    rep_x_nxt  = rep_x_r;
    rep_y_nxt  = rep_y_r;
    pend_x_nxt = pend_x_r;
    pend_y_nxt = pend_y_r;
    motion_nxt = motion_r;
    held_nxt   = held_r;
    ctrl_nxt   = ctrl_r;
    quit       = 1'b0;
    kw_v       = 1'b0;
    ch_v       = 1'b0;
    kword      = '0;
    cword      = '0;
    w0         = '0;
    w1         = '0;
    nw         = 2'd0;
    unique case (cmd)
      CMD_MOTION: begin
        pend_x_nxt = clamp_coord(pos_x, width_r);
        pend_y_nxt = clamp_coord(pos_y, height_r);
        motion_nxt = 1'b1;
      end
      CMD_BTN_DOWN, CMD_BTN_UP: begin
        if (bit_sel != 3'b000) begin
          held_nxt = (cmd == CMD_BTN_DOWN) ? (held_r | bit_sel) : (held_r & ~bit_sel);
          w0 = make_word((cmd == CMD_BTN_DOWN) ? EV_MDOWN : EV_MUP,
                         {{(DATA_W-BTN_W){1'b0}}, button_id});
          nw = 2'd1;
        end
      end
      CMD_KEY_DOWN, CMD_KEY_UP: begin
        if (sym_plain == SYM_CTRL_L || sym_plain == SYM_CTRL_R) begin
          ctrl_nxt = (cmd == CMD_KEY_DOWN);
        end
        if (cmd == CMD_KEY_DOWN && ctrl_nxt && sym_plain == SYM_Q) begin
          quit       = 1'b1;
          motion_nxt = 1'b0;
        end else begin
          kw_v  = (code != '0);
          kword = make_word((cmd == CMD_KEY_DOWN) ? EV_KDOWN : EV_KUP,
                            {{(DATA_W-CODE_W){1'b0}}, code});
          ch_v  = (cmd == CMD_KEY_DOWN) && ch >= PRINT_LO && ch <= PRINT_HI;
          cword = make_word(EV_CHAR, ch[DATA_W-1:0]);
          w0    = kw_v ? kword : (ch_v ? cword : '0);
          w1    = cword;
          nw    = {1'b0, kw_v} + {1'b0, ch_v};
        end
      end
      CMD_CLOSE: begin
        quit       = 1'b1;
        motion_nxt = 1'b0;
      end
      CMD_BATCH_END: begin
        if (motion_r) begin
          if (pend_x_r != rep_x_r || pend_y_r != rep_y_r) begin
            w0 = make_word(EV_MOVE, {pend_x_r, pend_y_r});
            nw = 2'd1;
          end
          rep_x_nxt  = pend_x_r;
          rep_y_nxt  = pend_y_r;
          motion_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    push_job.word0   = w0;
    push_job.word1   = w1;
    push_job.two     = (nw == 2'd2);
    push_job.has_ev  = (nw != 2'd0);
    push_job.quit    = quit;
    push_job.buttons = held_nxt;
    push_job.cur_x   = rep_x_nxt;
    push_job.cur_y   = rep_y_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      rep_x_r  <= '0;
      rep_y_r  <= '0;
      pend_x_r <= '0;
      pend_y_r <= '0;
      motion_r <= 1'b0;
      held_r   <= '0;
      ctrl_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SCREEN_WIDTH) begin
          width_r <= cfg_data;
        end else if (cfg_index == REG_SCREEN_HEIGHT) begin
          height_r <= cfg_data;
        end
      end
      if (push) begin
        rep_x_r  <= rep_x_nxt;
        rep_y_r  <= rep_y_nxt;
        pend_x_r <= pend_x_nxt;
        pend_y_r <= pend_y_nxt;
        motion_r <= motion_nxt;
        held_r   <= held_nxt;
        ctrl_r   <= ctrl_nxt;
      end
    end
  end

endmodule

// ===== rtl/core/kme_queue.sv =====
// Short job queue between the front end and the output stage.
module kme_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  kme_pkg::job_t    push_job,
  input  logic             pop,
  output kme_pkg::job_t    head_job,
  output kme_pkg::q_stat_t q_stat
);
  import kme_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign head_job     = mem_r[rptr_r];
  assign q_stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/kme_back.sv =====
// Output stage: holds one job and sends its one or two result beats.
module kme_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  kme_pkg::job_t                   head_job,
  input  kme_pkg::q_stat_t                q_stat,
  output logic                            pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic                            out_tuser,
  output logic [kme_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast
);
  import kme_pkg::*;

  job_t              cur_r;
  logic              cur_v_r;
  logic              sel_r;
  logic              take;
  logic [WORD_W-1:0] word;

  assign take       = cur_v_r && out_tready;
  assign out_tvalid = cur_v_r;
  assign out_tlast  = !cur_r.two || sel_r;
  assign out_tuser  = cur_r.has_ev;
  assign word       = sel_r ? cur_r.word1 : cur_r.word0;
  assign out_tdata  = {1'b0, cur_r.cur_y, cur_r.cur_x, cur_r.buttons, cur_r.quit, word};
  assign pop        = !q_stat.empty && (!cur_v_r || (take && out_tlast));

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      if (pop) begin
        cur_v_r <= 1'b1;
        sel_r   <= 1'b0;
      end else if (take) begin
        if (out_tlast) begin
          cur_v_r <= 1'b0;
          sel_r   <= 1'b0;
        end else begin
          sel_r <= 1'b1;
        end
      end
    end
  end

endmodule
